// ===== sv/gha_pkg.sv =====
package gha_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int GEN_W  = 16;

    typedef enum logic [1:0]
    {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_POP,
        S_IDX,
        S_RD,
        S_EXE,
        S_CLR_RD,
        S_CLR_WR,
        S_DONE
    } state_t;

    typedef struct packed
    {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [GEN_W-1:0]  wdata;
        logic [SLOT_W-1:0] raddr;
    } gen_port_t;

    typedef struct packed
    {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } stk_port_t;

endpackage

// ===== sv/gha_ifs.sv =====
interface gha_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic [gha_pkg::SLOT_W-1:0] handle_slot;
    logic [gha_pkg::GEN_W-1:0] handle_gen;
    logic                      handle_null;

    modport source (output valid, mode, handle_slot, handle_gen, handle_null, input ready);
    modport sink   (input valid, mode, handle_slot, handle_gen, handle_null, output ready);
endinterface

interface gha_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [gha_pkg::SLOT_W-1:0] out_slot;
    logic [gha_pkg::GEN_W-1:0] out_gen;
    logic [1:0]                status;

    modport source (output valid, out_slot, out_gen, status, input ready);
    modport sink   (input valid, out_slot, out_gen, status, output ready);
endinterface

// ===== sv/generational_handle_allocator.sv =====
// channel | dir | payload                                  | handshake
// req     | in  | mode, handle_slot, handle_gen, handle_null | valid/ready
// rsp     | out | out_slot, out_gen, status                 | valid/ready
//
// Validate, free and never-used-slot allocate run RD, EXE and DONE; allocate
// from the free stack first runs POP and IDX, and a full table goes straight
// to DONE; the steps follow the registered stack and generation RAM reads.
// Clear runs CLR_RD and CLR_WR per used slot, one generation RAM port per step.
// Reset clears counts, live and generation-valid bits at once; no sweep.
// req is taken only between requests; a waiting rsp holds the block in its
// last step, and a new request may be taken while a rsp waits.
module generational_handle_allocator (
    input logic       clk,
    input logic       rst_n,
    gha_req_if.sink   req,
    gha_rsp_if.source rsp
);

    gha_pkg::gen_port_t         gen_port;
    gha_pkg::stk_port_t         stk_port;
    logic [gha_pkg::GEN_W-1:0]  gen_rdata;
    logic [gha_pkg::SLOT_W-1:0] stk_rdata;

    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .gen_port  (gen_port),
        .gen_rdata (gen_rdata),
        .stk_port  (stk_port),
        .stk_rdata (stk_rdata)
    );

    gha_ram #(
        .DEPTH (gha_pkg::SLOTS),
        .WIDTH (gha_pkg::GEN_W)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_port.we),
        .waddr (gen_port.waddr),
        .wdata (gen_port.wdata),
        .raddr (gen_port.raddr),
        .rdata (gen_rdata)
    );

    gha_ram #(
        .DEPTH (gha_pkg::SLOTS),
        .WIDTH (gha_pkg::SLOT_W)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_port.we),
        .waddr (stk_port.waddr),
        .wdata (stk_port.wdata),
        .raddr (stk_port.raddr),
        .rdata (stk_rdata)
    );

endmodule

// ===== sv/gha_ram.sv =====
module gha_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/gha_ctrl.sv =====
module gha_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    gha_req_if.sink                     req,
    gha_rsp_if.source                   rsp,
    output gha_pkg::gen_port_t          gen_port,
    input  logic [gha_pkg::GEN_W-1:0]   gen_rdata,
    output gha_pkg::stk_port_t          stk_port,
    input  logic [gha_pkg::SLOT_W-1:0]  stk_rdata
);

    gha_pkg::state_t state_reg, state_next;
    gha_pkg::mode_t  mode_reg;
    gha_pkg::mode_t  req_mode;

    logic [gha_pkg::SLOT_W-1:0] hslot_reg;
    logic [gha_pkg::GEN_W-1:0]  hgen_reg;
    logic                       hnull_reg;
    logic [gha_pkg::SLOT_W-1:0] idx_reg;
    logic [gha_pkg::SLOT_W-1:0] ptr_reg;
    logic [gha_pkg::CNT_W-1:0]  free_cnt_reg;
    logic [gha_pkg::CNT_W-1:0]  used_cnt_reg;
    logic [gha_pkg::SLOTS-1:0]  live_reg;
    logic [gha_pkg::SLOTS-1:0]  gvld_reg;

    logic [gha_pkg::SLOT_W-1:0] res_slot_reg;
    logic [gha_pkg::GEN_W-1:0]  res_gen_reg;
    logic [1:0]                 res_stat_reg;

    logic                       out_vld_reg;
    logic [gha_pkg::SLOT_W-1:0] out_slot_reg;
    logic [gha_pkg::GEN_W-1:0]  out_gen_reg;
    logic [1:0]                 out_stat_reg;

    logic                       accept;
    logic                       out_free;
    logic                       clr_last;
    logic [gha_pkg::SLOT_W-1:0] unit_addr;
    logic [gha_pkg::GEN_W-1:0]  gen_cur;
    logic [gha_pkg::GEN_W-1:0]  gen_inc;
    logic                       gen_eq;
    logic                       handle_ok;

    assign req_mode = gha_pkg::mode_t'(req.mode);
    assign accept   = req.valid && req.ready;
    assign out_free = !out_vld_reg || rsp.ready;
    assign clr_last = ({1'b0, ptr_reg} + gha_pkg::CNT_W'(1)) == used_cnt_reg;

    // shared generation unit: select, increment, compare
    assign unit_addr = (state_reg == gha_pkg::S_CLR_WR) ? ptr_reg : idx_reg;
    assign gen_cur   = gvld_reg[unit_addr] ? gen_rdata : '0;
    assign gen_inc   = gen_cur + gha_pkg::GEN_W'(1);
    assign gen_eq    = gen_cur == hgen_reg;
    assign handle_ok = !hnull_reg && ({1'b0, idx_reg} < used_cnt_reg)
                       && live_reg[idx_reg] && gen_eq;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gha_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req_mode)
                        gha_pkg::MODE_ALLOC:
                        begin
                            if (free_cnt_reg != '0)
                                state_next = gha_pkg::S_POP;
                            else if (used_cnt_reg < gha_pkg::CNT_W'(gha_pkg::SLOTS))
                                state_next = gha_pkg::S_RD;
                            else
                                state_next = gha_pkg::S_DONE;
                        end
                        gha_pkg::MODE_FREE,
                        gha_pkg::MODE_CHECK:
                            state_next = gha_pkg::S_RD;
                        gha_pkg::MODE_CLEAR:
                        begin
                            if (used_cnt_reg == '0)
                                state_next = gha_pkg::S_DONE;
                            else
                                state_next = gha_pkg::S_CLR_RD;
                        end
                    endcase
                end
            end
            gha_pkg::S_POP:    state_next = gha_pkg::S_IDX;
            gha_pkg::S_IDX:    state_next = gha_pkg::S_RD;
            gha_pkg::S_RD:     state_next = gha_pkg::S_EXE;
            gha_pkg::S_EXE:    state_next = gha_pkg::S_DONE;
            gha_pkg::S_CLR_RD: state_next = gha_pkg::S_CLR_WR;
            gha_pkg::S_CLR_WR: state_next = clr_last ? gha_pkg::S_DONE : gha_pkg::S_CLR_RD;
            gha_pkg::S_DONE:   state_next = out_free ? gha_pkg::S_IDLE : gha_pkg::S_DONE;
        endcase
    end

    always_comb
    begin
        req.ready      = (state_reg == gha_pkg::S_IDLE);
        gen_port.we    = 1'b0;
        gen_port.waddr = unit_addr;
        gen_port.wdata = gen_inc;
        gen_port.raddr = (state_reg == gha_pkg::S_CLR_RD) ? ptr_reg : idx_reg;
        stk_port.we    = 1'b0;
        stk_port.waddr = free_cnt_reg[gha_pkg::SLOT_W-1:0];
        stk_port.wdata = idx_reg;
        stk_port.raddr = gha_pkg::SLOT_W'(free_cnt_reg - gha_pkg::CNT_W'(1));
        unique case (state_reg)
            gha_pkg::S_EXE:
            begin
                if (mode_reg == gha_pkg::MODE_FREE && handle_ok)
                begin
                    gen_port.we = 1'b1;
                    stk_port.we = free_cnt_reg < gha_pkg::CNT_W'(gha_pkg::SLOTS);
                end
            end
            gha_pkg::S_CLR_WR:
            begin
                gen_port.we    = 1'b1;
                stk_port.we    = 1'b1;
                stk_port.waddr = ptr_reg;
                stk_port.wdata = ptr_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid    = out_vld_reg;
    assign rsp.out_slot = out_slot_reg;
    assign rsp.out_gen  = out_gen_reg;
    assign rsp.status   = out_stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gha_pkg::S_IDLE;
            mode_reg     <= gha_pkg::MODE_ALLOC;
            free_cnt_reg <= '0;
            used_cnt_reg <= '0;
            live_reg     <= '0;
            gvld_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gha_pkg::S_DONE && out_free)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                gha_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= req_mode;
                        if (req_mode == gha_pkg::MODE_ALLOC && free_cnt_reg == '0
                            && used_cnt_reg < gha_pkg::CNT_W'(gha_pkg::SLOTS))
                            used_cnt_reg <= used_cnt_reg + gha_pkg::CNT_W'(1);
                    end
                end
                gha_pkg::S_POP:
                    free_cnt_reg <= free_cnt_reg - gha_pkg::CNT_W'(1);
                gha_pkg::S_EXE:
                begin
                    if (mode_reg == gha_pkg::MODE_ALLOC)
                        live_reg[idx_reg] <= 1'b1;
                    else if (mode_reg == gha_pkg::MODE_FREE && handle_ok)
                    begin
                        live_reg[idx_reg] <= 1'b0;
                        gvld_reg[idx_reg] <= 1'b1;
                        if (free_cnt_reg < gha_pkg::CNT_W'(gha_pkg::SLOTS))
                            free_cnt_reg <= free_cnt_reg + gha_pkg::CNT_W'(1);
                    end
                end
                gha_pkg::S_CLR_WR:
                begin
                    live_reg[ptr_reg] <= 1'b0;
                    gvld_reg[ptr_reg] <= 1'b1;
                    if (clr_last)
                        free_cnt_reg <= used_cnt_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gha_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    hslot_reg    <= req.handle_slot;
                    hgen_reg     <= req.handle_gen;
                    hnull_reg    <= req.handle_null;
                    ptr_reg      <= '0;
                    res_slot_reg <= '0;
                    res_gen_reg  <= '0;
                    if (req_mode == gha_pkg::MODE_ALLOC && free_cnt_reg == '0
                        && used_cnt_reg >= gha_pkg::CNT_W'(gha_pkg::SLOTS))
                        res_stat_reg <= gha_pkg::STAT_FULL;
                    else
                        res_stat_reg <= gha_pkg::STAT_OK;
                    if (req_mode == gha_pkg::MODE_ALLOC)
                        idx_reg <= used_cnt_reg[gha_pkg::SLOT_W-1:0];
                    else
                        idx_reg <= req.handle_slot;
                end
            end
            gha_pkg::S_IDX:
                idx_reg <= stk_rdata;
            gha_pkg::S_EXE:
            begin
                if (mode_reg == gha_pkg::MODE_ALLOC)
                begin
                    res_slot_reg <= idx_reg;
                    res_gen_reg  <= gen_cur;
                    res_stat_reg <= gha_pkg::STAT_OK;
                end
                else
                begin
                    res_slot_reg <= hslot_reg;
                    res_gen_reg  <= hgen_reg;
                    res_stat_reg <= handle_ok ? gha_pkg::STAT_OK : gha_pkg::STAT_BAD;
                end
            end
            gha_pkg::S_CLR_WR:
                ptr_reg <= ptr_reg + gha_pkg::SLOT_W'(1);
            gha_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_slot_reg <= res_slot_reg;
                    out_gen_reg  <= res_gen_reg;
                    out_stat_reg <= res_stat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sv/gha_checker.sv =====
module gha_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [gha_pkg::SLOT_W-1:0] out_slot,
    input logic [gha_pkg::GEN_W-1:0]  out_gen,
    input logic [1:0]                 status
);

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == gha_pkg::STAT_FULL) |-> (out_slot == '0 && out_gen == '0))
        else $error("full response carries a handle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == gha_pkg::STAT_OK || status == gha_pkg::STAT_FULL
                       || status == gha_pkg::STAT_BAD))
        else $error("undefined status code");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(out_slot)
                                       && $stable(out_gen)))
        else $error("stalled response changed");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_slot  (rsp.out_slot),
    .out_gen   (rsp.out_gen),
    .status    (rsp.status)
);
